// ===== hdl/pcgbr_pkg.sv =====
package pcgbr_pkg;

  localparam logic [63:0] PCG_MULT = 64'h5851_F42D_4C95_7F2D;
  localparam logic [63:0] PCG_INC  = 64'h1405_7B7E_F767_814F;

  // action codes carried in the input item
  localparam logic [1:0] ACT_SEED    = 2'd0;
  localparam logic [1:0] ACT_RAW     = 2'd1;
  localparam logic [1:0] ACT_BOUNDED = 2'd2;
  localparam logic [1:0] ACT_FRAC    = 2'd3;

  // operand selection for the shared 32x32 multiplier
  localparam logic [2:0] MUL_SL_ML  = 3'd0;
  localparam logic [2:0] MUL_SL_MH  = 3'd1;
  localparam logic [2:0] MUL_SH_ML  = 3'd2;
  localparam logic [2:0] MUL_RNG_W1 = 3'd3;
  localparam logic [2:0] MUL_RNG_W2 = 3'd4;

  typedef struct packed {
    logic       load;      // capture the accepted item
    logic [2:0] mul_sel;   // multiplier operand pair
    logic       acc_load;  // acc = product + increment
    logic       acc_add;   // upper acc half += product low half
    logic       commit;    // write the advanced state
    logic       cap_word;  // capture the permuted word of the current state
    logic       word_idx;  // 0: first word, 1: second word
    logic       save_hi;   // hold range * first word
    logic       save_bnd;  // form the bounded result
    logic       out_load;  // fill the output register
  } pcgbr_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       range_err;
  } pcgbr_stat_t;

endpackage

// ===== hdl/pcg32_bounded_random.sv =====
// PCG XSH-RR variant (xorshift of 21), 64-bit state, one result item per input
// item. The action in in_tuser picks seed (state = seed + increment, then one advance),
// raw 32-bit word, bounded integer in [range_low, range_high) built from two
// words with multiply-high steps, or a 24-bit unit fraction. A bounded request
// with range_low >= range_high (signed compare) returns range_low with range_error set and
// leaves the state alone. One input item is in flight at a time; the finished
// result waits in an output register, so the next item is taken while it
// waits. Every 64-bit state advance and every range product runs through one
// shared 32x32 multiplier. The generator state resets to zero.
module pcg32_bounded_random (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // seed_value[63:0], range_low[95:64], range_high[127:96]
  input  logic [1:0]   in_tuser,   // action[1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [87:0]  out_tdata,  // raw_word[31:0], bounded_value[63:32], unit_fraction[87:64]
  output logic [0:0]   out_tuser   // range_error[0]
);

  pcgbr_pkg::pcgbr_cmd_t  cmd;
  pcgbr_pkg::pcgbr_stat_t stat;

  logic [31:0] raw_word;
  logic [31:0] bounded_value;
  logic [23:0] unit_fraction;
  logic        range_error;

  // sequencer: owns the handshakes and steps the multiplier schedule
  pcgbr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // datapath: state, shared multiplier, word permute, result register
  pcgbr_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_action     (in_tuser),
    .in_seed       (in_tdata[63:0]),
    .in_low        (in_tdata[95:64]),
    .in_high       (in_tdata[127:96]),
    .raw_word      (raw_word),
    .bounded_value (bounded_value),
    .unit_fraction (unit_fraction),
    .range_error   (range_error)
  );

  // pack the result item
  assign out_tdata = {unit_fraction, bounded_value, raw_word};
  assign out_tuser = range_error;

endmodule

// ===== hdl/pcgbr_ctrl.sv =====
module pcgbr_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  pcgbr_pkg::pcgbr_stat_t stat,
  output pcgbr_pkg::pcgbr_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_W0    = 4'd2;
  localparam logic [3:0] S_W1    = 4'd3;
  localparam logic [3:0] S_W2    = 4'd4;
  localparam logic [3:0] S_W3    = 4'd5;
  localparam logic [3:0] S_R1    = 4'd6;
  localparam logic [3:0] S_R2    = 4'd7;
  localparam logic [3:0] S_R3    = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       second_r, second_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       bounded;

  assign bounded    = (stat.action == pcgbr_pkg::ACT_BOUNDED);
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    second_nxt   = second_r;
    cmd          = '0;
    cmd.mul_sel  = pcgbr_pkg::MUL_SL_ML;
    cmd.word_idx = second_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        second_nxt = 1'b0;
        if (bounded && stat.range_err) state_nxt = S_DONE;
        else                           state_nxt = S_W0;
      end
      S_W0: begin
        cmd.mul_sel  = pcgbr_pkg::MUL_SL_ML;
        cmd.cap_word = 1'b1;
        state_nxt    = S_W1;
      end
      S_W1: begin
        cmd.mul_sel  = pcgbr_pkg::MUL_SL_MH;
        cmd.acc_load = 1'b1;
        state_nxt    = S_W2;
      end
      S_W2: begin
        cmd.mul_sel = pcgbr_pkg::MUL_SH_ML;
        cmd.acc_add = 1'b1;
        state_nxt   = S_W3;
      end
      S_W3: begin
        cmd.commit = 1'b1;
        if (bounded && !second_r) begin
          second_nxt = 1'b1;
          state_nxt  = S_W0;
        end else if (bounded) begin
          state_nxt = S_R1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_R1: begin
        cmd.mul_sel = pcgbr_pkg::MUL_RNG_W1;
        state_nxt   = S_R2;
      end
      S_R2: begin
        cmd.mul_sel = pcgbr_pkg::MUL_RNG_W2;
        cmd.save_hi = 1'b1;
        state_nxt   = S_R3;
      end
      S_R3: begin
        cmd.save_bnd = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load)     out_valid_nxt = 1'b1;
    else if (out_tready)  out_valid_nxt = 1'b0;
    else                  out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      second_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      second_r    <= second_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // an accepted item always starts its decode step
  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_CHECK))
    else $error("accepted item did not enter decode");

  // never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("output register overwritten");

  // an empty range skips the generator entirely
  a_err_skip: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_CHECK) && bounded && stat.range_err) |=> (state_r == S_DONE))
    else $error("range error advanced the generator");

  // the range products follow only the second word of a bounded draw
  a_range_after_two: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_R1) |-> (second_r && bounded))
    else $error("range multiply without two words");

endmodule

// ===== hdl/pcgbr_dp.sv =====
module pcgbr_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pcgbr_pkg::pcgbr_cmd_t  cmd,
  output pcgbr_pkg::pcgbr_stat_t stat,
  input  logic [1:0]             in_action,
  input  logic [63:0]            in_seed,
  input  logic [31:0]            in_low,
  input  logic [31:0]            in_high,
  output logic [31:0]            raw_word,
  output logic [31:0]            bounded_value,
  output logic [23:0]            unit_fraction,
  output logic                   range_error
);

  logic [63:0] state_r;
  logic [1:0]  action_r;
  logic [31:0] low_r, high_r;
  logic [63:0] prod_r, acc_r, hi_r;
  logic [31:0] w1_r, w2_r, bnd_r;
  logic [31:0] raw_r, bval_r;
  logic [23:0] frac_r;
  logic        err_r;

  logic [63:0] xs;
  logic [31:0] xw, word;
  logic [63:0] ww;
  logic [4:0]  rot;
  logic [31:0] op_a, op_b, range;
  logic [63:0] prod_nxt;
  logic [32:0] lo_sum;
  logic [31:0] off;
  logic        err;

  // permuted output of the current state
  assign rot  = state_r[63:59];
  assign xs   = state_r ^ (state_r >> 21);
  assign xw   = xs[58:27];
  assign ww   = {xw, xw} >> rot;
  assign word = ww[31:0];

  assign err   = ($signed(low_r) >= $signed(high_r));
  assign range = high_r - low_r;

  assign stat.action    = action_r;
  assign stat.range_err = err;

  always_comb begin
    case (cmd.mul_sel)
      pcgbr_pkg::MUL_SL_ML:  begin op_a = state_r[31:0];  op_b = pcgbr_pkg::PCG_MULT[31:0];  end
      pcgbr_pkg::MUL_SL_MH:  begin op_a = state_r[31:0];  op_b = pcgbr_pkg::PCG_MULT[63:32]; end
      pcgbr_pkg::MUL_SH_ML:  begin op_a = state_r[63:32]; op_b = pcgbr_pkg::PCG_MULT[31:0];  end
      pcgbr_pkg::MUL_RNG_W1: begin op_a = range;          op_b = w1_r;                       end
      pcgbr_pkg::MUL_RNG_W2: begin op_a = range;          op_b = w2_r;                       end
      default:               begin op_a = '0;             op_b = '0;                         end
    endcase
  end

  assign prod_nxt = {32'd0, op_a} * {32'd0, op_b};

  assign lo_sum = {1'b0, hi_r[31:0]} + {1'b0, prod_r[63:32]};
  assign off    = hi_r[63:32] + {31'd0, lo_sum[32]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (cmd.load && (in_action == pcgbr_pkg::ACT_SEED)) begin
      state_r <= in_seed + pcgbr_pkg::PCG_INC;
    end else if (cmd.commit) begin
      state_r <= {acc_r[63:32] + prod_r[31:0], acc_r[31:0]};
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (cmd.load) begin
      action_r <= in_action;
      low_r    <= in_low;
      high_r   <= in_high;
    end
    if (cmd.acc_load) acc_r <= prod_r + pcgbr_pkg::PCG_INC;
    else if (cmd.acc_add) acc_r <= {acc_r[63:32] + prod_r[31:0], acc_r[31:0]};
    if (cmd.cap_word && !cmd.word_idx) w1_r <= word;
    if (cmd.cap_word && cmd.word_idx)  w2_r <= word;
    if (cmd.save_hi)  hi_r  <= prod_r;
    if (cmd.save_bnd) bnd_r <= low_r + off;
    if (cmd.out_load) begin
      raw_r  <= (action_r == pcgbr_pkg::ACT_RAW) ? w1_r : '0;
      frac_r <= (action_r == pcgbr_pkg::ACT_FRAC) ? w1_r[31:8] : '0;
      err_r  <= (action_r == pcgbr_pkg::ACT_BOUNDED) && err;
      if (action_r == pcgbr_pkg::ACT_BOUNDED) bval_r <= err ? low_r : bnd_r;
      else                                    bval_r <= '0;
    end
  end

  assign raw_word      = raw_r;
  assign bounded_value = bval_r;
  assign unit_fraction = frac_r;
  assign range_error   = err_r;

endmodule
